// ===== design/bfha_pkg.sv =====
package bfha_pkg;

    localparam int MAX_CELLS    = 64;
    localparam int ALIGN_BYTES  = 4;
    localparam int HEADER_BYTES = 8;
    localparam int OFFSET_BITS  = 16;
    localparam int IDX_BITS     = $clog2(MAX_CELLS);
    localparam int CNT_BITS     = $clog2(MAX_CELLS + 1);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NOMEM = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_BADH = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic REG_FACTOR = 1'b0;
    localparam logic REG_LIMIT  = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_PICK   = 7'b0000100,
        S_FREE   = 7'b0001000,
        S_TRIM   = 7'b0010000,
        S_TRIMCK = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

endpackage

// ===== design/best_fit_heap_allocator.sv =====
// Channel   Dir  Payload
// s_axis    in   tdata: cmd[0], request_size[16:1], free_handle[22:17]
// m_axis    out  tdata: status[1:0], cell_handle[7:2], data_offset[23:8],
//                       granted_size[39:24], reused[40]
// cfg       in   cfg_we, cfg_index (0 factor, 1 limit), cfg_data
// Allocate: one table read per cell; free: the handle is checked and, if it is good,
// each trailing free cell is then dropped in turn, with a read of its offset. The single
// read port of the cell memory sets this.
// Reset clears in-use bits, cell count and bump offset; cell memory is not cleared.
// Input is taken only when idle; a result waits in an output register for tready.
module best_fit_heap_allocator
    import bfha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // cmd, request_size, free_handle
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // status, cell_handle, data_offset, granted_size, reused
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [31:0] mem [MAX_CELLS];       // {offset, size}
    logic [31:0] rd_q;
    logic [IDX_BITS-1:0] raddr;
    logic        we;
    logic [IDX_BITS-1:0] waddr;
    logic [31:0] wdata;

    logic [MAX_CELLS-1:0] used_reg;
    logic [CNT_BITS-1:0]  count_reg;
    logic [OFFSET_BITS-1:0] bump_reg;
    logic [3:0]  factor_reg;
    logic [15:0] limit_reg;
    state_t      state_reg;

    logic [15:0] req_reg;
    logic [IDX_BITS-1:0] hnd_reg;
    logic [CNT_BITS-1:0] idx_reg;     // index being read
    logic        rvalid_reg;          // rd_q holds entry idx_reg-1
    logic        found_reg;
    logic [IDX_BITS-1:0] best_reg;
    logic [15:0] bsize_reg;
    logic [15:0] boff_reg;
    logic [19:0] reqmul_reg;

    logic        ovalid_reg;
    logic [47:0] odata_reg;

    logic [IDX_BITS-1:0] prev_idx;
    logic [17:0] aligned;
    logic [18:0] end_ofs;
    logic        fits;

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign prev_idx = IDX_BITS'(idx_reg - CNT_BITS'(1));
    assign aligned = (18'(req_reg) + 18'(ALIGN_BYTES - 1)) & ~18'(ALIGN_BYTES - 1);
    assign end_ofs = 19'(bump_reg) + 19'(aligned) + 19'(HEADER_BYTES);
    assign fits = (rd_q[15:0] >= req_reg) && (20'(rd_q[15:0]) <= reqmul_reg);

    // cell memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_q <= mem[raddr];
    end

    always_comb
    begin
        raddr = idx_reg[IDX_BITS-1:0];
        if (state_reg == S_IDLE)
        begin
            raddr = s_axis_tdata[22:17];
        end
        we = (state_reg == S_PICK) && !found_reg && (count_reg != CNT_BITS'(MAX_CELLS))
             && (end_ofs <= 19'(limit_reg));
        waddr = count_reg[IDX_BITS-1:0];
        wdata = {bump_reg, 16'(aligned)};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            count_reg  <= '0;
            bump_reg   <= '0;
            factor_reg <= 4'd2;
            limit_reg  <= 16'hFFFF;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FACTOR: factor_reg <= cfg_data[3:0];
                    REG_LIMIT:  limit_reg  <= cfg_data;
                    default:    limit_reg  <= cfg_data;
                endcase
            end
            if (ovalid_reg && m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        state_reg <= (s_axis_tdata[0] == CMD_FREE) ? S_FREE : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // the last entry is checked in the cycle that leaves the scan
                    if (idx_reg == count_reg)
                    begin
                        state_reg <= S_PICK;
                    end
                end
                S_PICK:
                begin
                    state_reg  <= S_IDLE;
                    ovalid_reg <= 1'b1;
                    if (found_reg)
                    begin
                        used_reg[best_reg] <= 1'b1;
                    end
                    else if (we)
                    begin
                        used_reg[count_reg[IDX_BITS-1:0]] <= 1'b1;
                        count_reg <= count_reg + CNT_BITS'(1);
                        bump_reg  <= end_ofs[15:0];
                    end
                end
                S_FREE:
                begin
                    ovalid_reg <= 1'b1;
                    if (CNT_BITS'(hnd_reg) >= count_reg || !used_reg[hnd_reg])
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        used_reg[hnd_reg] <= 1'b0;
                        state_reg <= S_TRIM;
                    end
                end
                S_TRIM:
                begin
                    // drop the last cell if free, reading its offset
                    if (count_reg == '0)
                    begin
                        bump_reg  <= '0;
                        state_reg <= S_IDLE;
                    end
                    else if (used_reg[IDX_BITS'(count_reg - CNT_BITS'(1))])
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        count_reg <= count_reg - CNT_BITS'(1);
                        state_reg <= S_TRIMCK;
                    end
                end
                S_TRIMCK:
                begin
                    bump_reg  <= rd_q[31:16];
                    state_reg <= S_TRIM;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                req_reg    <= s_axis_tdata[16:1];
                hnd_reg    <= s_axis_tdata[22:17];
                reqmul_reg <= 20'(s_axis_tdata[16:1]) * 20'(factor_reg);
                idx_reg    <= '0;
                rvalid_reg <= 1'b0;
                found_reg  <= 1'b0;
            end
            S_SCAN:
            begin
                if (rvalid_reg && !used_reg[prev_idx] && fits
                    && (!found_reg || rd_q[15:0] < bsize_reg))
                begin
                    found_reg <= 1'b1;
                    best_reg  <= prev_idx;
                    bsize_reg <= rd_q[15:0];
                    boff_reg  <= rd_q[31:16];
                end
                rvalid_reg <= idx_reg < count_reg;
                if (idx_reg < count_reg)
                begin
                    idx_reg <= idx_reg + CNT_BITS'(1);
                end
            end
            S_PICK:
            begin
                if (found_reg)
                begin
                    odata_reg <= {7'd0, 1'b1, bsize_reg, boff_reg + 16'(HEADER_BYTES),
                                  best_reg, ST_OK};
                end
                else if (count_reg == CNT_BITS'(MAX_CELLS))
                begin
                    odata_reg <= {46'd0, ST_FULL};
                end
                else if (!we)
                begin
                    odata_reg <= {46'd0, ST_NOMEM};
                end
                else
                begin
                    odata_reg <= {7'd0, 1'b0, 16'(aligned), bump_reg + 16'(HEADER_BYTES),
                                  count_reg[IDX_BITS-1:0], ST_OK};
                end
            end
            S_FREE:
            begin
                if (CNT_BITS'(hnd_reg) >= count_reg || !used_reg[hnd_reg])
                begin
                    odata_reg <= {40'd0, hnd_reg, ST_BADH};
                end
                else
                begin
                    odata_reg <= {7'd0, 1'b0, rd_q[15:0], rd_q[31:16] + 16'(HEADER_BYTES),
                                  hnd_reg, ST_OK};
                end
                idx_reg <= count_reg - CNT_BITS'(1);
            end
            S_TRIM:
            begin
                idx_reg <= count_reg - CNT_BITS'(1);
            end
            S_TRIMCK:
            begin
                // point at the new last cell for the next trim check
                idx_reg <= count_reg - CNT_BITS'(1);
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    // a result is never pending while a new item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input taken with result pending");

    // cell count never exceeds the table
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(MAX_CELLS))
        else $error("cell count overflow");

    // an empty table has its bump offset at the heap start after trimming
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TRIM && count_reg == '0) |=> bump_reg == '0)
        else $error("bump offset not reset");

endmodule

// ===== verif/testbench.sv =====
module testbench
    import bfha_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  handle;
        logic [15:0] offset;
        logic [15:0] granted;
        logic        reused;
    } grant_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    best_fit_heap_allocator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // Allocator mirror state
    logic [15:0] heap_sizes [MAX_CELLS];
    logic [15:0] heap_offsets [MAX_CELLS];
    logic        heap_busy [MAX_CELLS];
    int          heap_count;
    int          heap_bump;
    int          reuse_factor;
    int          heap_end;

    logic [23:0] pending_cmds [$];
    grant_t      expected_grants [$];
    int          idle_cycles;
    bit          failed;
    bit          cfg_req;
    logic        cfg_req_index;
    logic [15:0] cfg_req_data;

    // Work out the result of one command and update the mirror
    function automatic grant_t heap_model(logic [23:0] word);
        grant_t g;
        logic   is_free;
        int     req;
        int     hnd;
        int     best;
        int     aligned;
        is_free = word[0];
        req = word[16:1];
        hnd = word[22:17];
        best = -1;
        g = '0;
        if (is_free == CMD_ALLOC) begin
            for (int i = 0; i < heap_count; i++)
                if (!heap_busy[i] && heap_sizes[i] >= req && req * reuse_factor >= heap_sizes[i])
                    if (best < 0 || heap_sizes[i] < heap_sizes[best])
                        best = i;
            if (best >= 0) begin
                heap_busy[best] = 1'b1;
                g.status = ST_OK;
                g.handle = 6'(best);
                g.offset = 16'(heap_offsets[best] + HEADER_BYTES);
                g.granted = heap_sizes[best];
                g.reused = 1'b1;
            end
            else if (heap_count >= MAX_CELLS)
                g.status = ST_FULL;
            else begin
                aligned = ((req + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
                if (heap_bump + aligned + HEADER_BYTES > heap_end)
                    g.status = ST_NOMEM;
                else begin
                    heap_offsets[heap_count] = 16'(heap_bump);
                    heap_sizes[heap_count] = 16'(aligned);
                    heap_busy[heap_count] = 1'b1;
                    g.status = ST_OK;
                    g.handle = 6'(heap_count);
                    g.offset = 16'(heap_bump + HEADER_BYTES);
                    g.granted = 16'(aligned);
                    heap_count++;
                    heap_bump = heap_bump + aligned + HEADER_BYTES;
                end
            end
        end
        else if (hnd >= heap_count || !heap_busy[hnd]) begin
            g.status = ST_BADH;
            g.handle = 6'(hnd);
        end
        else begin
            heap_busy[hnd] = 1'b0;
            g.status = ST_OK;
            g.handle = 6'(hnd);
            g.offset = 16'(heap_offsets[hnd] + HEADER_BYTES);
            g.granted = heap_sizes[hnd];
            // drop trailing free cells
            while (heap_count > 0 && !heap_busy[heap_count - 1]) begin
                heap_count--;
                heap_bump = heap_offsets[heap_count];
            end
            if (heap_count == 0)
                heap_bump = 0;
        end
        return g;
    endfunction

    function automatic logic [23:0] alloc_cmd(int size);
        return {1'b0, 6'd0, size[15:0], CMD_ALLOC};
    endfunction

    function automatic logic [23:0] free_cmd(int hnd);
        return {1'b0, hnd[5:0], 16'd0, CMD_FREE};
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        return $urandom_range(0, 3);
    endfunction

    function automatic int random_size();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(0, 65535);
            2:       return $urandom_range(60000, 65535);
            default: return $urandom_range(1, 300);
        endcase
    endfunction

    // Driver: feed pending items with random gaps, apply register writes
    int drive_gap = 0;
    always @(posedge clk)
    begin
        cfg_we <= cfg_req;
        cfg_index <= cfg_req_index;
        cfg_data <= cfg_req_data;
        if (s_axis_tvalid && s_axis_tready)
            expected_grants.push_back(heap_model(s_axis_tdata));
        if (!s_axis_tvalid || s_axis_tready) begin
            if (drive_gap > 0) begin
                drive_gap <= drive_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_cmds.size() > 0 && rst_n) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_cmds.pop_front();
                drive_gap <= random_gap();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor: check each item against the oldest expectation
    always @(posedge clk)
    begin
        grant_t got;
        grant_t want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[1:0], m_axis_tdata[7:2], m_axis_tdata[23:8],
                   m_axis_tdata[39:24], m_axis_tdata[40]};
            if (expected_grants.size() == 0) begin
                $display("%0t: unexpected item %h", $time, got);
                failed = 1'b1;
            end
            else begin
                want = expected_grants.pop_front();
                if (got.status !== want.status)
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                if (got.handle !== want.handle)
                    $display("%0t: handle exp %0d got %0d", $time, want.handle, got.handle);
                if (got.offset !== want.offset)
                    $display("%0t: offset exp %0d got %0d", $time, want.offset, got.offset);
                if (got.granted !== want.granted)
                    $display("%0t: size exp %0d got %0d", $time, want.granted, got.granted);
                if (got.reused !== want.reused)
                    $display("%0t: reused exp %0d got %0d", $time, want.reused, got.reused);
                if (got !== want)
                    failed = 1'b1;
            end
        end
        if ($urandom_range(0, 3) == 0)
            m_axis_tready <= 1'b1;
        else if ($urandom_range(0, 3) == 0)
            m_axis_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : m_axis_tready;
        else
            m_axis_tready <= ($urandom_range(0, 2) != 0);
    end

    // Watchdog: count cycles with nothing accepted
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (pending_cmds.size() == 0 && expected_grants.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Hold until every expected item is back, then let trimming settle
    task automatic drain();
        while (pending_cmds.size() > 0 || s_axis_tvalid || expected_grants.size() > 0)
            @(negedge clk);
        repeat (2 * MAX_CELLS + 10) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int value);
        if (idx == REG_FACTOR)
            reuse_factor = value & 15;
        else
            heap_end = value & 16'hFFFF;
        cfg_req_index <= idx;
        cfg_req_data <= 16'(value);
        cfg_req <= 1'b1;
        @(posedge clk);
        cfg_req <= 1'b0;
        @(posedge clk);
        @(posedge clk);
    endtask

    task automatic random_phase(int count);
        int live;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 6)
                pending_cmds.push_back(alloc_cmd(random_size()));
            else if ($urandom_range(0, 9) == 0)
                pending_cmds.push_back({1'b0, 6'($urandom_range(0, 63)), 16'($urandom()),
                                        CMD_FREE});
            else begin
                live = $urandom_range(0, MAX_CELLS - 1);
                pending_cmds.push_back(free_cmd($urandom_range(0, 20) == 0 ? 63 : live % 24));
            end
        end
        drain();
    endtask

    initial
    begin
        reuse_factor = 2;
        heap_end = 65535;
        heap_count = 0;
        heap_bump = 0;
        idle_cycles = 0;
        failed = 1'b0;
        cfg_req = 1'b0;
        cfg_req_index = REG_FACTOR;
        cfg_req_data = '0;
        foreach (heap_busy[i])
            heap_busy[i] = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero request, extremes, reuse, bad handles, empty table
        pending_cmds.push_back(free_cmd(0));
        pending_cmds.push_back(alloc_cmd(0));
        pending_cmds.push_back(alloc_cmd(1));
        pending_cmds.push_back(alloc_cmd(100));
        pending_cmds.push_back(alloc_cmd(65535));
        pending_cmds.push_back(alloc_cmd(8));
        pending_cmds.push_back(free_cmd(2));
        pending_cmds.push_back(free_cmd(2));
        pending_cmds.push_back(alloc_cmd(60));
        pending_cmds.push_back(alloc_cmd(50));
        pending_cmds.push_back(free_cmd(63));
        pending_cmds.push_back(free_cmd(1));
        pending_cmds.push_back(free_cmd(0));
        pending_cmds.push_back(alloc_cmd(0));
        pending_cmds.push_back(free_cmd(0));
        pending_cmds.push_back(free_cmd(3));
        pending_cmds.push_back(free_cmd(2));
        pending_cmds.push_back(alloc_cmd(65532));
        pending_cmds.push_back(alloc_cmd(65533));
        drain();

        // Fill the table with small cells until it is full
        write_reg(REG_FACTOR, 0);
        for (int i = 0; i < MAX_CELLS + 3; i++)
            pending_cmds.push_back(alloc_cmd(i % 5));
        pending_cmds.push_back(free_cmd(5));
        pending_cmds.push_back(alloc_cmd(0));
        pending_cmds.push_back(alloc_cmd(4));
        drain();
        for (int i = MAX_CELLS - 1; i >= 0; i--)
            pending_cmds.push_back(free_cmd(i));
        drain();

        random_phase(60);
        write_reg(REG_FACTOR, 15);
        write_reg(REG_LIMIT, 2000);
        random_phase(60);
        write_reg(REG_LIMIT, 0);
        write_reg(REG_FACTOR, 1);
        random_phase(30);
        write_reg(REG_LIMIT, 65535);
        write_reg(REG_FACTOR, 3);
        random_phase(100);

        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
